// ===== rtl/sfcr_pkg.sv =====
// Package for the short-frame CRC-16 receiver: item types, codes and CRC step.
`default_nettype none

package sfcr_pkg;

   localparam int COUNT_W = 3;
   localparam logic [COUNT_W-1:0] COUNT_SAT = 3'd6;
   localparam int FRAME_DEPTH = 5;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_LEN = 2'd1,
      STATUS_CRC_ERR = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       burst_end;
   } req_data_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  device_id;
      logic [7:0]  function_code;
      logic [7:0]  argument;
      logic [15:0] received_crc;
   } rsp_data_type;

   // Input stage to frame checker
   typedef struct packed {
      logic         valid;
      req_data_type data;
   } item_type;

   // One byte of CRC-16/MODBUS, reflected, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sfcr_in_stage.sv =====
// Input register stage of the short-frame CRC-16 receiver.
`default_nettype none

module sfcr_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire sfcr_pkg::req_data_type req_data,
   input  wire logic                  advance,
   output sfcr_pkg::item_type         item
);

   logic                   valid_ff, valid_in;
   sfcr_pkg::req_data_type data_ff, data_in;
   logic                   accept;

   // Holds only while its item cannot move on to the checker
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/sfcr_frame_check.sv =====
// Frame state, CRC update and result register of the short-frame CRC-16 receiver.
`default_nettype none

module sfcr_frame_check (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sfcr_pkg::item_type item,
   output logic                    advance,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sfcr_pkg::rsp_data_type  rsp_data
);

   logic [sfcr_pkg::COUNT_W-1:0] count_ff, count_in, count_inc;
   logic [7:0]  frame_ff [sfcr_pkg::FRAME_DEPTH];
   logic [7:0]  frame_in [sfcr_pkg::FRAME_DEPTH];
   logic [15:0] crc_run_ff, crc_run_in;
   logic [15:0] crc_two_ff, crc_two_in;
   logic [15:0] crc_three_ff, crc_three_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sfcr_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic        step;
   logic        result;
   logic [15:0] crc_next;
   logic [15:0] calc;
   logic [15:0] recv;
   logic [7:0]  b;

   // Pipeline moves unless a result sits unaccepted
   assign advance = !(rsp_valid_ff && rsp_stall);
   assign step    = item.valid && advance;
   assign b       = item.data.rx_byte;

   assign crc_next  = sfcr_pkg::crc_byte(crc_run_ff, b);
   assign count_inc = (count_ff < sfcr_pkg::COUNT_SAT) ? count_ff + 1'b1 : count_ff;

   always_comb begin
      count_in     = count_ff;
      crc_run_in   = crc_run_ff;
      crc_two_in   = crc_two_ff;
      crc_three_in = crc_three_ff;
      for (int i = 0; i < sfcr_pkg::FRAME_DEPTH; i++) begin
         frame_in[i] = frame_ff[i];
      end
      result       = 1'b0;
      calc         = crc_two_ff;
      recv         = 16'h0000;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (step) begin
         for (int i = 0; i < sfcr_pkg::FRAME_DEPTH; i++) begin
            if (count_ff == i[sfcr_pkg::COUNT_W-1:0]) begin
               frame_in[i] = b;
            end
         end
         if (count_ff < 3'd3) begin
            crc_run_in = crc_next;
            if (count_ff == 3'd1) begin
               crc_two_in = crc_next;
            end else if (count_ff == 3'd2) begin
               crc_three_in = crc_next;
            end
         end
         count_in = count_inc;

         result = item.data.burst_end && (count_inc >= 3'd4);

         if (count_inc == 3'd4) begin
            calc = crc_two_ff;
            recv = {frame_in[3], frame_in[2]};
         end else begin
            calc = crc_three_ff;
            recv = {frame_in[4], frame_in[3]};
         end

         if (count_inc == sfcr_pkg::COUNT_SAT) begin
            rsp_data_in = '0;
            rsp_data_in.status = sfcr_pkg::STATUS_BAD_LEN;
         end else begin
            rsp_data_in.status        = (calc == recv) ? sfcr_pkg::STATUS_OK
                                                       : sfcr_pkg::STATUS_CRC_ERR;
            rsp_data_in.device_id     = frame_in[0];
            rsp_data_in.function_code = frame_in[1];
            rsp_data_in.argument      = (count_inc == 3'd5) ? frame_in[2] : 8'h00;
            rsp_data_in.received_crc  = recv;
         end

         if (result) begin
            count_in     = '0;
            crc_run_in   = sfcr_pkg::CRC_INIT;
            crc_two_in   = sfcr_pkg::CRC_INIT;
            crc_three_in = sfcr_pkg::CRC_INIT;
         end
      end

      if (advance) begin
         rsp_valid_in = result;
      end
      if (!(advance && result)) begin
         rsp_data_in = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         crc_run_ff   <= sfcr_pkg::CRC_INIT;
         crc_two_ff   <= sfcr_pkg::CRC_INIT;
         crc_three_ff <= sfcr_pkg::CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         crc_run_ff   <= crc_run_in;
         crc_two_ff   <= crc_two_in;
         crc_three_ff <= crc_three_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      for (int i = 0; i < sfcr_pkg::FRAME_DEPTH; i++) begin
         frame_ff[i] <= frame_in[i];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_sat : assert property (@(posedge clock) disable iff (reset)
      count_ff <= sfcr_pkg::COUNT_SAT)
      else $error("byte count above saturation");

   a_clear_after_result : assert property (@(posedge clock) disable iff (reset)
      step && result |=> count_ff == '0 && crc_run_ff == sfcr_pkg::CRC_INIT)
      else $error("frame state not cleared after result");

   a_two_untouched : assert property (@(posedge clock) disable iff (reset)
      count_ff < 3'd2 |-> crc_two_ff == sfcr_pkg::CRC_INIT)
      else $error("two-byte CRC snapshot taken early");

   a_three_untouched : assert property (@(posedge clock) disable iff (reset)
      count_ff < 3'd3 |-> crc_three_ff == sfcr_pkg::CRC_INIT)
      else $error("three-byte CRC snapshot taken early");

   a_bad_len_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == sfcr_pkg::STATUS_BAD_LEN
      |-> rsp_data_ff.device_id == 8'h00 && rsp_data_ff.received_crc == 16'h0000)
      else $error("bad-length result carries frame fields");

endmodule

`default_nettype wire

// ===== rtl/short_frame_crc16_receiver_top.sv =====
// Usage: short-frame CRC-16 receiver top level.
// Input channel (req_*): one received byte per item with a burst-end flag.
// Bytes collect across bursts; at a burst end with four or five bytes
// the frame is checked against its little-endian CRC-16/MODBUS trailer,
// with six or more it is dropped as bad length, with fewer it waits.
// Result channel (rsp_*): one item per evaluated frame with status,
// device id, function code, argument (zero for four-byte frames) and
// received CRC. Bad-length results carry zero fields.
// A result is registered: the byte that ends the frame passes the input
// register, then the checker into the result register. Throughput: one byte
// per cycle unless a result stalls; the CRC byte step is one registered pass.
// Reset clears the byte count and CRC state; no frame is in progress.
// While rsp_stall holds a result, the checker halts and req_stall rises
// once the input register is full; nothing is dropped.
`default_nettype none

module short_frame_crc16_receiver_top (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire sfcr_pkg::req_data_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output sfcr_pkg::rsp_data_type      rsp_data
);

   sfcr_pkg::item_type item;
   logic               advance;

   sfcr_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .item      (item)
   );

   sfcr_frame_check u_frame_check (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
